/* rtl/ctdg_pkg.sv */
// Shared types, widths and helpers for the trilinear distance/gradient pipeline.
// No dependencies; used by every module of the block by scoped name.
package ctdg_pkg;

  localparam int SAMPLE_W   = 32;                  // corner and result sample width
  localparam int COORD_W    = 17;                  // coordinate width, Q0.16 plus the 1.0 code
  localparam int COORD_FRAC = 16;                  // fraction bits of a coordinate
  localparam int VAL_W      = SAMPLE_W + 2;        // internal value width (face diffs + headroom)
  localparam int DELTA_W    = VAL_W + 1;           // q - p
  localparam int PROD_W     = DELTA_W + COORD_W + 1;
  localparam int LERP_LAT   = 3;                   // register stages in one lerp unit
  localparam int LATENCY    = 12;                  // accept edge to sampled done

  localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << COORD_FRAC;
  localparam logic [PROD_W-1:0]  PROD_HALF  = PROD_W'(1) << (COORD_FRAC - 1);

  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COORD_W-1:0]         coord_t;

  typedef struct packed {
    val_t x;
    val_t y;
    val_t z;
  } grad_t;

  function automatic val_t widen(input sample_t v);
    return {{(VAL_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic sample_t sat(input val_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[VAL_W-1:SAMPLE_W-1];
    hi_zeros = ~|v[VAL_W-1:SAMPLE_W-1];
    if (hi_ones || hi_zeros) begin
      return v[SAMPLE_W-1:0];
    end else if (v[VAL_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  function automatic coord_t clamp(input coord_t c);
    return (c > COORD_ONE) ? COORD_ONE : c;
  endfunction

endpackage

/* rtl/ctdg_lerp.sv */
// One linear step p + floor(((q - p) * t + half) / one), three register stages.
// Depends on ctdg_pkg.
module ctdg_lerp (
  input  logic           clk,
  input  ctdg_pkg::val_t   p,
  input  ctdg_pkg::val_t   q,
  input  ctdg_pkg::coord_t t,
  output ctdg_pkg::val_t   r
);

  logic signed [ctdg_pkg::DELTA_W-1:0] delta;
  ctdg_pkg::val_t                      p_s1;
  ctdg_pkg::coord_t                    t_s1;
  logic signed [ctdg_pkg::PROD_W-1:0]  prod;
  ctdg_pkg::val_t                      p_s2;
  logic [ctdg_pkg::PROD_W-1:0]         rnd;
  ctdg_pkg::val_t                      r_next;

  // stage 1: difference
  always_ff @(posedge clk) begin
    delta <= ctdg_pkg::DELTA_W'(q) - ctdg_pkg::DELTA_W'(p);
    p_s1  <= p;
    t_s1  <= t;
  end

  // stage 2: product, t taken as non-negative
  always_ff @(posedge clk) begin
    prod <= ctdg_pkg::PROD_W'(delta * $signed({1'b0, t_s1}));
    p_s2 <= p_s1;
  end

  // stage 3: round half up, floor shift, add base (result fits, wrap is exact)
  always_comb begin
    rnd    = prod + ctdg_pkg::PROD_HALF;
    r_next = p_s2 + ctdg_pkg::val_t'(rnd[ctdg_pkg::COORD_FRAC +: ctdg_pkg::VAL_W]);
  end

  always_ff @(posedge clk) begin
    r <= r_next;
  end

  a_t_zero: assert property (@(posedge clk)
    ($past(t, ctdg_pkg::LERP_LAT) == '0) |-> (r == $past(p, ctdg_pkg::LERP_LAT)))
    else $error("lerp with t=0 did not return p");

  a_t_one: assert property (@(posedge clk)
    ($past(t, ctdg_pkg::LERP_LAT) == ctdg_pkg::COORD_ONE) |-> (r == $past(q, ctdg_pkg::LERP_LAT)))
    else $error("lerp with t=1 did not return q");

endmodule

/* rtl/ctdg_out.sv */
// Output register: saturation, threshold compare and the done strobe.
// Depends on ctdg_pkg.
module ctdg_out (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  ctdg_pkg::val_t          dist_val,
  input  ctdg_pkg::grad_t         grad,
  input  ctdg_pkg::sample_t       threshold,
  output logic                    done,
  output ctdg_pkg::sample_t       distance,
  output ctdg_pkg::sample_t       gradient_x,
  output ctdg_pkg::sample_t       gradient_y,
  output ctdg_pkg::sample_t       gradient_z,
  output logic                    gradient_valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    distance       <= ctdg_pkg::sat(dist_val);
    gradient_x     <= ctdg_pkg::sat(grad.x);
    gradient_y     <= ctdg_pkg::sat(grad.y);
    gradient_z     <= ctdg_pkg::sat(grad.z);
    gradient_valid <= (dist_val <= ctdg_pkg::widen(threshold));
  end

endmodule

/* rtl/cell_trilinear_distance_and_gradient.sv */
// Top level of the trilinear distance and gradient pipeline.
// Depends on ctdg_pkg, ctdg_lerp and ctdg_out.
//
// Each item carries the eight corner distances of one cell (Q16.16, corner
// index bit 0 = x, bit 1 = y, bit 2 = z) and a point in the cell (Q0.16,
// 65536 = 1.0, larger codes clamp to 1.0). The block returns the trilinear
// distance, a per-axis gradient estimate (low-face minus high-face corner
// differences, bilinear over the two other axes) and gradient_valid, set when
// distance <= normal_threshold. busy is always low: a new item may be
// started on every clock. The result appears on the output ports with done
// high for one cycle, driven from the output register after the z step; the
// result side cannot stall, so it must be captured in that cycle. The latency
// is set by the chain of three dependent lerp steps (x, then y, then z), each
// a 3-stage unit (difference, multiply, round and add), plus an input register,
// a face-difference stage and the output register. Write normal_threshold only
// while no items are in flight.
module cell_trilinear_distance_and_gradient (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  ctdg_pkg::sample_t       corner_0,
  input  ctdg_pkg::sample_t       corner_1,
  input  ctdg_pkg::sample_t       corner_2,
  input  ctdg_pkg::sample_t       corner_3,
  input  ctdg_pkg::sample_t       corner_4,
  input  ctdg_pkg::sample_t       corner_5,
  input  ctdg_pkg::sample_t       corner_6,
  input  ctdg_pkg::sample_t       corner_7,
  input  ctdg_pkg::coord_t        local_x,
  input  ctdg_pkg::coord_t        local_y,
  input  ctdg_pkg::coord_t        local_z,
  input  logic                    normal_threshold_we,
  input  ctdg_pkg::sample_t       normal_threshold,
  output logic                    done,
  output ctdg_pkg::sample_t       distance,
  output ctdg_pkg::sample_t       gradient_x,
  output ctdg_pkg::sample_t       gradient_y,
  output ctdg_pkg::sample_t       gradient_z,
  output logic                    gradient_valid
);

  typedef struct packed {
    ctdg_pkg::coord_t x;
    ctdg_pkg::coord_t y;
    ctdg_pkg::coord_t z;
  } point_t;

  localparam int VPIPE = 11;   // valid bits for stages R0..R10
  localparam int NL1   = 10;   // first-level lerps: 4 distance, 6 gradient
  localparam int NL2   = 5;    // second-level lerps: 2 distance, 3 gradient

  logic                     accept;
  logic [VPIPE-1:0]         vld;
  ctdg_pkg::sample_t        thr;

  // R0: registered inputs
  ctdg_pkg::sample_t        crn [8];
  point_t                   pt_r0;

  // R1: corners widened, face differences
  ctdg_pkg::val_t           crn_r1 [8];
  ctdg_pkg::val_t           dgx [4];
  ctdg_pkg::val_t           dgy [4];
  ctdg_pkg::val_t           dgz [4];
  point_t                   pt_r1;

  // point delayed alongside the lerp chain, R2..R7
  point_t                   pt_dly [6];

  ctdg_pkg::val_t           l1_p [NL1];
  ctdg_pkg::val_t           l1_q [NL1];
  ctdg_pkg::coord_t         l1_t [NL1];
  ctdg_pkg::val_t           l1_r [NL1];
  ctdg_pkg::val_t           l2_p [NL2];
  ctdg_pkg::val_t           l2_q [NL2];
  ctdg_pkg::coord_t         l2_t [NL2];
  ctdg_pkg::val_t           l2_r [NL2];
  ctdg_pkg::val_t           dist_r10;

  // gradients wait R7..R10 for the last distance step
  ctdg_pkg::grad_t          g_r7;
  ctdg_pkg::grad_t          g_dly [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (normal_threshold_we) begin
      thr <= normal_threshold;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[VPIPE-2:0], accept};
    end
  end

  // R0
  always_ff @(posedge clk) begin
    crn[0]  <= corner_0;
    crn[1]  <= corner_1;
    crn[2]  <= corner_2;
    crn[3]  <= corner_3;
    crn[4]  <= corner_4;
    crn[5]  <= corner_5;
    crn[6]  <= corner_6;
    crn[7]  <= corner_7;
    pt_r0.x <= ctdg_pkg::clamp(local_x);
    pt_r0.y <= ctdg_pkg::clamp(local_y);
    pt_r0.z <= ctdg_pkg::clamp(local_z);
  end

  // R1: low-face minus high-face, pairs in ascending corner order
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      crn_r1[i] <= ctdg_pkg::widen(crn[i]);
    end
    dgx[0] <= ctdg_pkg::widen(crn[0]) - ctdg_pkg::widen(crn[1]);
    dgx[1] <= ctdg_pkg::widen(crn[2]) - ctdg_pkg::widen(crn[3]);
    dgx[2] <= ctdg_pkg::widen(crn[4]) - ctdg_pkg::widen(crn[5]);
    dgx[3] <= ctdg_pkg::widen(crn[6]) - ctdg_pkg::widen(crn[7]);
    dgy[0] <= ctdg_pkg::widen(crn[0]) - ctdg_pkg::widen(crn[2]);
    dgy[1] <= ctdg_pkg::widen(crn[1]) - ctdg_pkg::widen(crn[3]);
    dgy[2] <= ctdg_pkg::widen(crn[4]) - ctdg_pkg::widen(crn[6]);
    dgy[3] <= ctdg_pkg::widen(crn[5]) - ctdg_pkg::widen(crn[7]);
    dgz[0] <= ctdg_pkg::widen(crn[0]) - ctdg_pkg::widen(crn[4]);
    dgz[1] <= ctdg_pkg::widen(crn[1]) - ctdg_pkg::widen(crn[5]);
    dgz[2] <= ctdg_pkg::widen(crn[2]) - ctdg_pkg::widen(crn[6]);
    dgz[3] <= ctdg_pkg::widen(crn[3]) - ctdg_pkg::widen(crn[7]);
    pt_r1  <= pt_r0;
  end

  always_ff @(posedge clk) begin
    pt_dly[0] <= pt_r1;
    for (int i = 1; i < 6; i++) begin
      pt_dly[i] <= pt_dly[i-1];
    end
  end

  // Level 1 (R1 -> R4):
  //   0..3 distance x step on pairs (0,1),(2,3),(4,5),(6,7)
  //   4,5  gx hi/lo over y;  6,7 gy hi/lo over x;  8,9 gz hi/lo over x
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      l1_p[i] = crn_r1[2*i];
      l1_q[i] = crn_r1[2*i+1];
      l1_t[i] = pt_r1.x;
    end
    l1_p[4] = dgx[1];  l1_q[4] = dgx[0];  l1_t[4] = pt_r1.y;
    l1_p[5] = dgx[3];  l1_q[5] = dgx[2];  l1_t[5] = pt_r1.y;
    l1_p[6] = dgy[1];  l1_q[6] = dgy[0];  l1_t[6] = pt_r1.x;
    l1_p[7] = dgy[3];  l1_q[7] = dgy[2];  l1_t[7] = pt_r1.x;
    l1_p[8] = dgz[1];  l1_q[8] = dgz[0];  l1_t[8] = pt_r1.x;
    l1_p[9] = dgz[3];  l1_q[9] = dgz[2];  l1_t[9] = pt_r1.x;
  end

  for (genvar g = 0; g < NL1; g++) begin : g_l1
    ctdg_lerp u_lerp (
      .clk (clk),
      .p   (l1_p[g]),
      .q   (l1_q[g]),
      .t   (l1_t[g]),
      .r   (l1_r[g])
    );
  end

  // Level 2 (R4 -> R7): distance y step; each gradient lerp(lo, hi, b)
  always_comb begin
    l2_p[0] = l1_r[0];  l2_q[0] = l1_r[1];  l2_t[0] = pt_dly[2].y;
    l2_p[1] = l1_r[2];  l2_q[1] = l1_r[3];  l2_t[1] = pt_dly[2].y;
    l2_p[2] = l1_r[5];  l2_q[2] = l1_r[4];  l2_t[2] = pt_dly[2].z;
    l2_p[3] = l1_r[7];  l2_q[3] = l1_r[6];  l2_t[3] = pt_dly[2].z;
    l2_p[4] = l1_r[9];  l2_q[4] = l1_r[8];  l2_t[4] = pt_dly[2].y;
  end

  for (genvar g = 0; g < NL2; g++) begin : g_l2
    ctdg_lerp u_lerp (
      .clk (clk),
      .p   (l2_p[g]),
      .q   (l2_q[g]),
      .t   (l2_t[g]),
      .r   (l2_r[g])
    );
  end

  // Level 3 (R7 -> R10): distance z step
  ctdg_lerp u_lerp_z (
    .clk (clk),
    .p   (l2_r[0]),
    .q   (l2_r[1]),
    .t   (pt_dly[5].z),
    .r   (dist_r10)
  );

  assign g_r7.x = l2_r[2];
  assign g_r7.y = l2_r[3];
  assign g_r7.z = l2_r[4];

  always_ff @(posedge clk) begin
    g_dly[0] <= g_r7;
    g_dly[1] <= g_dly[0];
    g_dly[2] <= g_dly[1];
  end

  ctdg_out u_out (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (vld[VPIPE-1]),
    .dist_val       (dist_r10),
    .grad           (g_dly[2]),
    .threshold      (thr),
    .done           (done),
    .distance       (distance),
    .gradient_x     (gradient_x),
    .gradient_y     (gradient_y),
    .gradient_z     (gradient_z),
    .gradient_valid (gradient_valid)
  );

  a_item_returns: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(ctdg_pkg::LATENCY) done)
    else $error("accepted item produced no result at fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, ctdg_pkg::LATENCY))
    else $error("result without a matching accepted item");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (gradient_valid == (distance <= $past(thr))))
    else $error("gradient_valid disagrees with distance and threshold");

endmodule

/* dv/cell_trilinear_distance_and_gradient_checker.sv */
// Checker for the trilinear distance and gradient block: predicts each result
// from the accepted item and compares it with the result marked by done.
// Depends on ctdg_pkg for the sample and coordinate types and constants.
module cell_trilinear_distance_and_gradient_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  ctdg_pkg::sample_t       corner_0,
  input  ctdg_pkg::sample_t       corner_1,
  input  ctdg_pkg::sample_t       corner_2,
  input  ctdg_pkg::sample_t       corner_3,
  input  ctdg_pkg::sample_t       corner_4,
  input  ctdg_pkg::sample_t       corner_5,
  input  ctdg_pkg::sample_t       corner_6,
  input  ctdg_pkg::sample_t       corner_7,
  input  ctdg_pkg::coord_t        local_x,
  input  ctdg_pkg::coord_t        local_y,
  input  ctdg_pkg::coord_t        local_z,
  input  logic                    normal_threshold_we,
  input  ctdg_pkg::sample_t       normal_threshold,
  input  logic                    done,
  input  ctdg_pkg::sample_t       distance,
  input  ctdg_pkg::sample_t       gradient_x,
  input  ctdg_pkg::sample_t       gradient_y,
  input  ctdg_pkg::sample_t       gradient_z,
  input  logic                    gradient_valid,
  output int unsigned             answers_pending,
  output int unsigned             miscompares
);

  localparam longint UNIT      = longint'(1) << ctdg_pkg::COORD_FRAC;
  localparam longint UNIT_HALF = UNIT >> 1;

  typedef struct {
    ctdg_pkg::sample_t distance;
    ctdg_pkg::sample_t grad_x;
    ctdg_pkg::sample_t grad_y;
    ctdg_pkg::sample_t grad_z;
    logic              valid;
  } cell_answer_t;

  cell_answer_t answers_due [$];
  longint       threshold_now;

  function automatic longint coord_weight(input ctdg_pkg::coord_t c);
    return (c > ctdg_pkg::COORD_ONE) ? UNIT : longint'(c);
  endfunction

  // one linear step, exact products, round half up
  function automatic longint blend(input longint lo_v, input longint hi_v, input longint t);
    return (lo_v * (UNIT - t) + hi_v * t + UNIT_HALF) >>> ctdg_pkg::COORD_FRAC;
  endfunction

  function automatic longint face_slope(input longint d0, input longint d1, input longint d2,
                                        input longint d3, input longint a, input longint b);
    return blend(blend(d3, d2, a), blend(d1, d0, a), b);
  endfunction

  function automatic ctdg_pkg::sample_t clip32(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < longint'(32'sh80000000)) return 32'sh80000000;
    return ctdg_pkg::sample_t'(v);
  endfunction

  function automatic cell_answer_t predict_answer();
    longint s [8];
    longint x, y, z, dist_val;
    cell_answer_t ans;
    s[0] = corner_0; s[1] = corner_1; s[2] = corner_2; s[3] = corner_3;
    s[4] = corner_4; s[5] = corner_5; s[6] = corner_6; s[7] = corner_7;
    x = coord_weight(local_x);
    y = coord_weight(local_y);
    z = coord_weight(local_z);
    dist_val = blend(blend(blend(s[0], s[1], x), blend(s[2], s[3], x), y),
                     blend(blend(s[4], s[5], x), blend(s[6], s[7], x), y), z);
    ans.distance = clip32(dist_val);
    ans.grad_x = clip32(face_slope(s[0] - s[1], s[2] - s[3], s[4] - s[5], s[6] - s[7], y, z));
    ans.grad_y = clip32(face_slope(s[0] - s[2], s[1] - s[3], s[4] - s[6], s[5] - s[7], x, z));
    ans.grad_z = clip32(face_slope(s[0] - s[4], s[1] - s[5], s[2] - s[6], s[3] - s[7], x, y));
    ans.valid = (dist_val <= threshold_now);
    return ans;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (miscompares < 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
      miscompares++;
    end
  endtask

  always @(posedge clk) begin : watch
    cell_answer_t want;
    if (rst) begin
      answers_due.delete();
      threshold_now = 0;
    end else begin
      if (done === 1'b1) begin
        if (answers_due.size() == 0) begin
          if (miscompares < 10)
            $display("%0t: result with no item outstanding", $time);
          miscompares++;
        end else begin
          want = answers_due.pop_front();
          check_field("distance", want.distance, distance);
          check_field("gradient_x", want.grad_x, gradient_x);
          check_field("gradient_y", want.grad_y, gradient_y);
          check_field("gradient_z", want.grad_z, gradient_z);
          check_field("gradient_valid", 32'(want.valid), 32'(gradient_valid));
        end
      end else if (done !== 1'b0) begin
        if (miscompares < 10)
          $display("%0t: done is unknown", $time);
        miscompares++;
      end
      if (start === 1'b1 && busy === 1'b0)
        answers_due.push_back(predict_answer());
      if (normal_threshold_we === 1'b1)
        threshold_now = normal_threshold;
    end
    answers_pending <= answers_due.size();
  end

endmodule

/* dv/cell_trilinear_distance_and_gradient_test.sv */
// Testbench top for the trilinear distance and gradient block: drives items and
// threshold writes, gives the verdict. Depends on ctdg_pkg, the block and its checker.
module cell_trilinear_distance_and_gradient_test;

  localparam ctdg_pkg::sample_t S_MAX       = 32'sh7FFFFFFF;
  localparam ctdg_pkg::sample_t S_MIN       = 32'sh80000000;
  localparam ctdg_pkg::coord_t  C_ONE       = ctdg_pkg::COORD_ONE;
  localparam ctdg_pkg::coord_t  C_HALF      = 17'h08000;
  localparam ctdg_pkg::coord_t  C_TOP       = 17'h1FFFF;   // largest code, clamps to 1.0
  localparam int                PHASES      = 8;
  localparam int                PHASE_ITEMS = 175;
  localparam int                CHUNK       = 25;          // items per idling pattern

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  ctdg_pkg::sample_t corner [8];
  ctdg_pkg::coord_t  local_x;
  ctdg_pkg::coord_t  local_y;
  ctdg_pkg::coord_t  local_z;
  logic              normal_threshold_we;
  ctdg_pkg::sample_t normal_threshold;
  logic              done;
  ctdg_pkg::sample_t distance;
  ctdg_pkg::sample_t gradient_x;
  ctdg_pkg::sample_t gradient_y;
  ctdg_pkg::sample_t gradient_z;
  logic              gradient_valid;
  int unsigned       answers_pending;
  int unsigned       miscompares;

  bit                quiet;          // no idling for the current chunk of items
  ctdg_pkg::sample_t threshold_set;  // last value written to normal_threshold

  cell_trilinear_distance_and_gradient u_top (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .corner_0            (corner[0]),
    .corner_1            (corner[1]),
    .corner_2            (corner[2]),
    .corner_3            (corner[3]),
    .corner_4            (corner[4]),
    .corner_5            (corner[5]),
    .corner_6            (corner[6]),
    .corner_7            (corner[7]),
    .local_x             (local_x),
    .local_y             (local_y),
    .local_z             (local_z),
    .normal_threshold_we (normal_threshold_we),
    .normal_threshold    (normal_threshold),
    .done                (done),
    .distance            (distance),
    .gradient_x          (gradient_x),
    .gradient_y          (gradient_y),
    .gradient_z          (gradient_z),
    .gradient_valid      (gradient_valid)
  );

  cell_trilinear_distance_and_gradient_checker u_check (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .corner_0            (corner[0]),
    .corner_1            (corner[1]),
    .corner_2            (corner[2]),
    .corner_3            (corner[3]),
    .corner_4            (corner[4]),
    .corner_5            (corner[5]),
    .corner_6            (corner[6]),
    .corner_7            (corner[7]),
    .local_x             (local_x),
    .local_y             (local_y),
    .local_z             (local_z),
    .normal_threshold_we (normal_threshold_we),
    .normal_threshold    (normal_threshold),
    .done                (done),
    .distance            (distance),
    .gradient_x          (gradient_x),
    .gradient_y          (gradient_y),
    .gradient_z          (gradient_z),
    .gradient_valid      (gradient_valid),
    .answers_pending     (answers_pending),
    .miscompares         (miscompares)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; a correct run takes a small fraction of this.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Present one item and hold it until the block takes it. cv packs the
  // corners with corner 0 in the low 32 bits. start is left high so that a
  // following item can go back to back.
  task automatic drive_cell(input logic [255:0] cv, input ctdg_pkg::coord_t x,
                            input ctdg_pkg::coord_t y, input ctdg_pkg::coord_t z);
    for (int i = 0; i < 8; i++) corner[i] <= cv[32*i +: 32];
    local_x <= x;
    local_y <= y;
    local_z <= z;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sender gap after an item: mostly none or short, now and then long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) n = 0;
    else if (r < 80) n = $urandom_range(1, 3);
    else if (r < 96) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain the pipe completely, then write the threshold. Every item yields a
  // result, so an empty expectation queue means nothing is in flight.
  task automatic set_threshold(input ctdg_pkg::sample_t v);
    start <= 1'b0;
    do @(posedge clk); while (answers_pending != 0);
    normal_threshold_we <= 1'b1;
    normal_threshold    <= v;
    threshold_set        = v;
    @(posedge clk);
    normal_threshold_we <= 1'b0;
  endtask

  // Corner values: extremes, small values around zero, or anything.
  function automatic ctdg_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3, 4: return ctdg_pkg::sample_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return ctdg_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Coordinates: ends of the cell, midpoint, codes above 1.0, or inside.
  function automatic ctdg_pkg::coord_t pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return C_ONE;
      2:       return ctdg_pkg::coord_t'($urandom_range(int'(C_ONE) + 1, int'(C_TOP)));
      3:       return C_ONE - 17'd1;
      4:       return C_HALF;
      default: return ctdg_pkg::coord_t'($urandom_range(0, int'(C_ONE)));
    endcase
  endfunction

  // Random item. Some cells sit right at the threshold so that the
  // at-or-below compare gets its edge, some put a random full-scale extreme on
  // each corner to push the gradients into saturation.
  task automatic random_cell();
    logic [255:0] cv;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0:       cv[32*i +: 32] = threshold_set;
        1:       cv[32*i +: 32] = ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
        2:       cv[32*i +: 32] = threshold_set +
                                  ctdg_pkg::sample_t'($urandom_range(0, 8)) - 32'sd4;
        default: cv[32*i +: 32] = pick_sample();
      endcase
    end
    drive_cell(cv, pick_coord(), pick_coord(), pick_coord());
    idle_gap();
  endtask

  function automatic ctdg_pkg::sample_t phase_threshold(input int p);
    case (p)
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return -32'sd1;
      3:       return 32'sh00010000;
      4:       return ctdg_pkg::sample_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return ctdg_pkg::sample_t'($urandom);
    endcase
  endfunction

  initial begin
    rst                 = 1'b1;
    start               = 1'b0;
    for (int i = 0; i < 8; i++) corner[i] = '0;
    local_x             = '0;
    local_y             = '0;
    local_z             = '0;
    normal_threshold_we = 1'b0;
    normal_threshold    = '0;
    threshold_set       = '0;
    quiet               = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items, threshold still at its reset value of zero.
    // Flat zero cell: distance equals the threshold, so valid is set.
    drive_cell('0, '0, '0, '0);                                         idle_gap();
    drive_cell({8{S_MAX}}, C_ONE, C_ONE, C_ONE);                        idle_gap();
    // coordinates far above one must clamp
    drive_cell({8{S_MIN}}, C_TOP, C_TOP, C_TOP);                        idle_gap();
    // full-scale steps along each axis: face differences overflow 32 bits
    drive_cell({4{S_MAX, S_MIN}}, C_HALF, C_HALF, C_HALF);              idle_gap();
    drive_cell({4{S_MIN, S_MAX}}, '0, '0, '0);                          idle_gap();
    drive_cell({2{S_MAX, S_MAX, S_MIN, S_MIN}}, C_ONE, '0, C_ONE);      idle_gap();
    drive_cell({2{S_MIN, S_MIN, S_MAX, S_MAX}}, C_TOP, C_HALF, '0);     idle_gap();
    drive_cell({{4{S_MAX}}, {4{S_MIN}}}, C_HALF, C_HALF, C_HALF);       idle_gap();
    drive_cell({{4{S_MIN}}, {4{S_MAX}}}, C_ONE, C_ONE, '0);             idle_gap();
    // exact halves: rounding goes up for both signs
    drive_cell({192'd0, 32'sd1, 32'sd0}, C_HALF, '0, '0);               idle_gap();
    drive_cell({192'd0, -32'sd1, 32'sd0}, C_HALF, '0, '0);              idle_gap();
    drive_cell({32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
               '0, C_HALF, C_HALF);                                     idle_gap();
    // ramp of corner index in integer units
    drive_cell({32'h70000, 32'h60000, 32'h50000, 32'h40000,
                32'h30000, 32'h20000, 32'h10000, 32'h00000},
               17'h04000, 17'h0C000, 17'h12345);                       idle_gap();
    // lone hot far corner: distance 1.0 sits above the threshold
    drive_cell({32'h10000, 224'd0}, C_ONE, C_ONE, C_ONE);              idle_gap();
    drive_cell({8{-32'sd1}}, C_HALF, 17'h00001, C_ONE - 17'd1);        idle_gap();
    drive_cell({8{32'sd1}}, C_ONE + 17'd1, C_ONE + 17'd1, C_ONE + 17'd1); idle_gap();
    drive_cell({S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN},
               C_ONE - 17'd1, C_ONE - 17'd1, C_ONE - 17'd1);            idle_gap();
    drive_cell({8{32'hFFFF_FFFF}}, 17'h1_5555, 17'h0_AAAA, '0);        idle_gap();

    // Random phases, each under its own threshold. Each write drains the
    // pipe first, which also covers the sender waiting on every result.
    for (int p = 0; p < PHASES; p++) begin
      set_threshold(phase_threshold(p));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % CHUNK == 0) quiet = ($urandom_range(0, 3) == 0);
        random_cell();
      end
    end

    // Let everything come out, then wait longer than the pipeline latency for stray results.
    start <= 1'b0;
    do @(posedge clk); while (answers_pending != 0);
    repeat (ctdg_pkg::LATENCY + 4) @(posedge clk);
    if (miscompares == 0 && answers_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ctdg_pkg.sv
rtl/ctdg_lerp.sv
rtl/ctdg_out.sv
rtl/cell_trilinear_distance_and_gradient.sv
dv/cell_trilinear_distance_and_gradient_checker.sv
dv/cell_trilinear_distance_and_gradient_test.sv
